@@ rtl/rtr_pkg.sv @@
// shared types and codes for the rational to integer rounder
`default_nettype none

package rtr_pkg;

   typedef enum logic [2:0] {
      RM_HALF_AWAY = 3'd0,
      RM_HALF_ZERO = 3'd1,
      RM_HALF_EVEN = 3'd2,
      RM_HALF_ODD  = 3'd3,
      RM_TRUNC     = 3'd4,
      RM_AWAY      = 3'd5,
      RM_FLOOR     = 3'd6,
      RM_CEIL      = 3'd7
   } round_mode_type;

   typedef struct packed {
      logic signed [63:0] numerator;
      logic [62:0]        denominator;
      round_mode_type     round_mode;
   } req_type;

   typedef struct packed {
      logic signed [63:0] rounded_value;
      logic               divide_by_zero;
   } rsp_type;

   // control that rides along the divider chain with each transaction
   typedef struct packed {
      logic           valid;
      logic           neg;
      logic           dz;
      round_mode_type mode;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/rtr_front.sv @@
// input stage: sign split, magnitude and denominator capture
`default_nettype none

module rtr_front #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire rtr_pkg::req_type      req_data,
   output rtr_pkg::ctl_type           ctl_o,
   output logic [DATA_WIDTH-2:0]      den_o,
   output logic [DATA_WIDTH-1:0]      work_o
);
   import rtr_pkg::*;

   logic [DATA_WIDTH-1:0] num;
   logic [DATA_WIDTH-2:0] den;
   ctl_type               ctl_in, ctl_ff;
   logic [DATA_WIDTH-1:0] mag_in, mag_ff;
   logic [DATA_WIDTH-2:0] den_ff;

   always_comb begin
      num           = req_data.numerator[DATA_WIDTH-1:0];
      den           = req_data.denominator[DATA_WIDTH-2:0];
      ctl_in.valid  = accept;
      ctl_in.neg    = num[DATA_WIDTH-1];
      ctl_in.dz     = (den == '0);
      ctl_in.mode   = req_data.round_mode;
      // most negative value maps to 2^(w-1), which still fits unsigned
      mag_in        = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      den_ff <= den;
   end

   assign ctl_o  = ctl_ff;
   assign den_o  = den_ff;
   assign work_o = mag_ff;

endmodule

`default_nettype wire

@@ rtl/rtr_div_cell.sv @@
// one restoring divider cell: resolves one quotient bit per stage
`default_nettype none

module rtr_div_cell #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rtr_pkg::ctl_type      ctl_i,
   input  wire logic [DATA_WIDTH-2:0] den_i,
   input  wire logic [DATA_WIDTH-2:0] rem_i,
   input  wire logic [DATA_WIDTH-1:0] work_i,
   output rtr_pkg::ctl_type           ctl_o,
   output logic [DATA_WIDTH-2:0]      den_o,
   output logic [DATA_WIDTH-2:0]      rem_o,
   output logic [DATA_WIDTH-1:0]      work_o
);
   import rtr_pkg::*;

   logic [DATA_WIDTH-1:0] trial;
   logic [DATA_WIDTH-1:0] diff;
   logic                  ge;
   logic [DATA_WIDTH-2:0] rem_in, rem_ff;
   logic [DATA_WIDTH-1:0] work_in, work_ff;
   logic [DATA_WIDTH-2:0] den_ff;
   ctl_type               ctl_ff;

   // work holds unused dividend bits on top, quotient bits fill from the bottom
   always_comb begin
      trial   = {rem_i, work_i[DATA_WIDTH-1]};
      diff    = trial - {1'b0, den_i};
      ge      = (trial >= {1'b0, den_i});
      rem_in  = ge ? diff[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];
      work_in = {work_i[DATA_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_i;
   end

   assign ctl_o  = ctl_ff;
   assign den_o  = den_ff;
   assign rem_o  = rem_ff;
   assign work_o = work_ff;

endmodule

`default_nettype wire

@@ rtl/rtr_round.sv @@
// rounding stage: picks the quotient or its away neighbor, then restores the sign, or gives zero for a zero denominator
`default_nettype none

module rtr_round #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rtr_pkg::ctl_type      ctl_i,
   input  wire logic [DATA_WIDTH-2:0] den_i,
   input  wire logic [DATA_WIDTH-2:0] rem_i,
   input  wire logic [DATA_WIDTH-1:0] quo_i,
   output logic                       rsp_valid,
   output rtr_pkg::rsp_type           rsp_data
);
   import rtr_pkg::*;

   logic [DATA_WIDTH-1:0]        away;
   logic [DATA_WIDTH-2:0]        other;
   logic                         gt;
   logic                         eq;
   logic [DATA_WIDTH-1:0]        pick;
   logic [DATA_WIDTH-1:0]        mag_in, mag_ff;
   ctl_type                      ctl_ff;
   logic signed [DATA_WIDTH-1:0] res;
   rsp_type                      rsp_in, rsp_ff;
   logic                         valid_ff;

   always_comb begin
      away  = quo_i + 1'b1;
      // tie test without doubling the remainder
      other = den_i - rem_i;
      gt    = (rem_i > other);
      eq    = (rem_i == other);
      unique case (ctl_i.mode)
         RM_HALF_AWAY: pick = (gt || eq) ? away : quo_i;
         RM_HALF_ZERO: pick = gt ? away : quo_i;
         RM_HALF_EVEN: pick = eq ? (quo_i[0] ? away : quo_i) : (gt ? away : quo_i);
         RM_HALF_ODD:  pick = eq ? (quo_i[0] ? quo_i : away) : (gt ? away : quo_i);
         RM_TRUNC:     pick = quo_i;
         RM_AWAY:      pick = away;
         RM_FLOOR:     pick = ctl_i.neg ? away : quo_i;
         RM_CEIL:      pick = ctl_i.neg ? quo_i : away;
         default:      pick = quo_i;
      endcase
      mag_in = (rem_i == '0) ? quo_i : pick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
   end

   always_comb begin
      if (ctl_ff.dz) begin
         res = '0;
      end else if (ctl_ff.neg) begin
         res = signed'(~mag_ff + 1'b1);
      end else begin
         res = signed'(mag_ff);
      end
      rsp_in.rounded_value  = 64'(res);
      rsp_in.divide_by_zero = ctl_ff.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/rational_to_integer_rounder.sv @@
// top level: input stage, chain of divider cells and rounding stage
`default_nettype none

// Divides a signed numerator by a positive denominator and rounds the quotient to an
// integer in one of eight modes. The block is never busy: it takes a transaction in
// every cycle that start is high, and each result appears on the rsp_ ports for one
// cycle with rsp_valid high, in order, once it has passed through the input stage,
// the divider chain (one cell per quotient bit) and the two rounding stages. Results
// cannot be held off, so the receiver must take each one in the cycle it is shown. A
// zero denominator gives divide_by_zero high and a rounded_value of zero.
module rational_to_integer_rounder #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rtr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output rtr_pkg::rsp_type      rsp_data
);
   import rtr_pkg::*;

   ctl_type               ctl  [0:DATA_WIDTH];
   logic [DATA_WIDTH-2:0] den  [0:DATA_WIDTH];
   logic [DATA_WIDTH-2:0] rem  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] work [0:DATA_WIDTH];
   logic                  accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rtr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .ctl_o    (ctl[0]),
      .den_o    (den[0]),
      .work_o   (work[0])
   );

   assign rem[0] = '0;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      rtr_div_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl[i]),
         .den_i  (den[i]),
         .rem_i  (rem[i]),
         .work_i (work[i]),
         .ctl_o  (ctl[i+1]),
         .den_o  (den[i+1]),
         .rem_o  (rem[i+1]),
         .work_o (work[i+1])
      );
   end

   rtr_round #(.DATA_WIDTH(DATA_WIDTH)) u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (ctl[DATA_WIDTH]),
      .den_i     (den[DATA_WIDTH]),
      .rem_i     (rem[DATA_WIDTH]),
      .quo_i     (work[DATA_WIDTH]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/rtr_checker.sv @@
// port-level checks for the rounder, bound to the top level
`default_nettype none

module rtr_checker #(
   parameter int DATA_WIDTH = 64
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire rtr_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire rtr_pkg::rsp_type rsp_data
);
   import rtr_pkg::*;

   localparam int LATENCY = DATA_WIDTH + 3;

   // never stalls the requester
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   // every transaction comes back after the fixed latency
   a_start_to_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("result missing after transaction");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LATENCY !rsp_valid)
      else $error("result without transaction");

   // zero flag follows the denominator of the matching transaction
   a_dz_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.divide_by_zero ==
         ($past(req_data.denominator[DATA_WIDTH-2:0], LATENCY) == '0)))
      else $error("divide_by_zero does not match denominator");

   // a nonzero result carries the numerator's sign; a flagged one is zero
   a_sign_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.rounded_value != '0)) |->
         (!rsp_data.divide_by_zero && (rsp_data.rounded_value[63] ==
            $past(req_data.numerator[DATA_WIDTH-1], LATENCY))))
      else $error("result sign or zero-denominator value wrong");

endmodule

bind rational_to_integer_rounder rtr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (.*);

`default_nettype wire

@@ bench/rational_to_integer_rounder_tb.sv @@
// testbench for the rational to integer rounder: directed table, then random divisions
`default_nettype none

module rational_to_integer_rounder_tb;
   import rtr_pkg::*;

   localparam int DATA_WIDTH   = 64;
   localparam int LATENCY      = DATA_WIDTH + 3;
   localparam int RANDOM_ITEMS = 600;

   localparam logic signed [63:0] MOST_NEG = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] MOST_POS = 64'sh7fff_ffff_ffff_ffff;
   localparam logic [62:0]        DEN_MAX  = 63'h7fff_ffff_ffff_ffff;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type          pending_quotients[$];
   directed_row_type division_table[$];
   int               failures;
   int               results_checked;
   int               zero_den_results;
   int               divisions_issued;

   rational_to_integer_rounder #(
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // truncating division of the magnitudes, then the mode picks quotient or its outer neighbor
   function automatic rsp_type rounded_quotient(req_type r);
      logic [63:0] num_bits;
      logic [63:0] divisor;
      logic [63:0] mag;
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] other;
      logic [63:0] away;
      logic [63:0] pick;
      logic        neg;
      rsp_type     res;
      num_bits = r.numerator;
      divisor  = {1'b0, r.denominator};
      neg      = num_bits[63];
      mag      = neg ? (~num_bits + 64'd1) : num_bits;
      res      = '0;
      if (divisor == 64'd0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      quo   = mag / divisor;
      rem   = mag % divisor;
      away  = quo + 64'd1;
      other = divisor - rem;
      if (rem == 64'd0) begin
         pick = quo;
      end else begin
         case (r.round_mode)
            RM_HALF_AWAY: pick = (rem >= other) ? away : quo;
            RM_HALF_ZERO: pick = (rem > other) ? away : quo;
            RM_HALF_EVEN: begin
               if (rem != other) pick = (rem > other) ? away : quo;
               else pick = quo[0] ? away : quo;
            end
            RM_HALF_ODD: begin
               if (rem != other) pick = (rem > other) ? away : quo;
               else pick = quo[0] ? quo : away;
            end
            RM_TRUNC: pick = quo;
            RM_AWAY:  pick = away;
            RM_FLOOR: pick = neg ? away : quo;
            default:  pick = neg ? quo : away;
         endcase
      end
      res.rounded_value = neg ? (~pick + 64'd1) : pick;
      return res;
   endfunction

   function automatic void add_row(logic signed [63:0] num, logic [62:0] den,
                                   round_mode_type mode, bit typed,
                                   logic signed [63:0] value, logic dz);
      directed_row_type row;
      row.req.numerator         = num;
      row.req.denominator       = den;
      row.req.round_mode        = mode;
      row.typed                 = typed;
      row.want.rounded_value    = value;
      row.want.divide_by_zero   = dz;
      division_table.push_back(row);
   endfunction

   function automatic logic [63:0] wide_random();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_type random_division();
      req_type     r;
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] den;
      logic        neg;
      neg          = 1'($urandom_range(0, 1));
      r.round_mode = round_mode_type'($urandom_range(0, 7));
      mag          = '0;
      den          = '0;
      case ($urandom_range(0, 9))
         0: begin
            mag = wide_random();
            den = $urandom_range(0, 1) ? 64'd0 : 64'd1;
         end
         1, 2: begin
            // exact ties: remainder is half of an even denominator
            half = $urandom_range(0, 1) ? 64'($urandom_range(1, 8)) : 64'($urandom());
            if (half == 0) half = 64'd1;
            den = half << 1;
            mag = 64'($urandom_range(0, 1 << 20)) * den + half;
         end
         3: begin
            den = 64'($urandom_range(1, 1000));
            mag = (wide_random() >> 24) * den;
         end
         4: begin
            case ($urandom_range(0, 4))
               0: mag = MOST_NEG;
               1: mag = MOST_POS;
               2: mag = 64'd0;
               3: mag = 64'hffff_ffff_ffff_ffff;
               default: mag = 64'd1;
            endcase
            den = $urandom_range(0, 1) ? 64'($urandom_range(1, 16))
                                       : ((wide_random() >> 1) >> $urandom_range(0, 62));
            if (den == 0) den = 64'd3;
            neg = 1'b0;
         end
         5, 6: begin
            mag = 64'($urandom_range(0, 200));
            den = 64'($urandom_range(1, 16));
         end
         default: begin
            mag = wide_random();
            den = (wide_random() >> 1) >> $urandom_range(0, 62);
            neg = 1'b0;
         end
      endcase
      r.numerator   = neg ? (~mag + 64'd1) : mag;
      r.denominator = den[62:0];
      return r;
   endfunction

   task automatic issue_division(req_type r, bit typed, rsp_type want);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_quotients.push_back(typed ? want : rounded_quotient(r));
      divisions_issued++;
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_quotients.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_quotients.size() == 0) begin
            log_failure($sformatf("unexpected result: value %0d dz %0b",
                                  rsp_data.rounded_value, rsp_data.divide_by_zero));
         end else begin
            want = pending_quotients.pop_front();
            results_checked++;
            if (rsp_data.divide_by_zero === 1'b1) zero_den_results++;
            if (rsp_data.rounded_value !== want.rounded_value ||
                rsp_data.divide_by_zero !== want.divide_by_zero) begin
               log_failure($sformatf("mismatch: expected value %0d dz %0b, got value %0d dz %0b",
                                     want.rounded_value, want.divide_by_zero,
                                     rsp_data.rounded_value, rsp_data.divide_by_zero));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** rational_to_integer_rounder: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int burst_left;
      failures         = 0;
      results_checked  = 0;
      zero_den_results = 0;
      divisions_issued = 0;
      burst_left       = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;

      // zero denominator, exact quotients and zero numerator are known at a glance
      add_row(64'sd0,    63'd0,   RM_HALF_AWAY, 1'b1, 64'sd0,   1'b1);
      add_row(MOST_NEG,  63'd0,   RM_CEIL,      1'b1, 64'sd0,   1'b1);
      add_row(MOST_NEG,  63'd1,   RM_FLOOR,     1'b1, MOST_NEG, 1'b0);
      add_row(MOST_POS,  63'd1,   RM_AWAY,      1'b1, MOST_POS, 1'b0);
      add_row(64'sd0,    DEN_MAX, RM_TRUNC,     1'b1, 64'sd0,   1'b0);
      add_row(-64'sd1,   63'd1,   RM_HALF_EVEN, 1'b1, -64'sd1,  1'b0);
      add_row(MOST_POS,  DEN_MAX, RM_HALF_ODD,  1'b1, 64'sd1,   1'b0);
      // ties and plain fractions in every mode
      add_row(64'sd5,    63'd2,   RM_HALF_AWAY, 1'b0, '0, 1'b0);
      add_row(-64'sd5,   63'd2,   RM_HALF_ZERO, 1'b0, '0, 1'b0);
      add_row(64'sd5,    63'd2,   RM_HALF_EVEN, 1'b0, '0, 1'b0);
      add_row(64'sd7,    63'd2,   RM_HALF_EVEN, 1'b0, '0, 1'b0);
      add_row(-64'sd7,   63'd2,   RM_HALF_ODD,  1'b0, '0, 1'b0);
      add_row(64'sd5,    63'd2,   RM_HALF_ODD,  1'b0, '0, 1'b0);
      add_row(64'sd7,    63'd3,   RM_TRUNC,     1'b0, '0, 1'b0);
      add_row(-64'sd7,   63'd3,   RM_AWAY,      1'b0, '0, 1'b0);
      add_row(-64'sd7,   63'd3,   RM_FLOOR,     1'b0, '0, 1'b0);
      add_row(-64'sd7,   63'd3,   RM_CEIL,      1'b0, '0, 1'b0);
      add_row(64'sd7,    63'd3,   RM_FLOOR,     1'b0, '0, 1'b0);
      add_row(64'sd7,    63'd3,   RM_CEIL,      1'b0, '0, 1'b0);
      add_row(MOST_NEG,  DEN_MAX, RM_AWAY,      1'b0, '0, 1'b0);
      add_row(MOST_NEG,  63'd2,   RM_HALF_ODD,  1'b0, '0, 1'b0);
      add_row(MOST_POS,  63'd2,   RM_HALF_EVEN, 1'b0, '0, 1'b0);
      add_row(-64'sd1,   DEN_MAX, RM_HALF_AWAY, 1'b0, '0, 1'b0);
      add_row(64'sd1,    63'd2,   RM_HALF_ZERO, 1'b0, '0, 1'b0);
      add_row(-64'sd1,   63'd2,   RM_HALF_AWAY, 1'b0, '0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (division_table[i])
         issue_division(division_table[i].req, division_table[i].typed, division_table[i].want);
      wait_for_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) wait_for_results();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
         end
         issue_division(random_division(), 1'b0, '0);
         burst_left--;
      end

      wait_for_results();
      repeat (LATENCY + 8) @(posedge clock);

      $display("issued %0d divisions (%0d directed), checked %0d results, %0d by zero",
               divisions_issued, division_table.size(), results_checked, zero_den_results);
      $display("covered ties, exact quotients and extremes in all eight rounding modes");
      if (failures == 0) begin
         $display("** rational_to_integer_rounder: PASSED **");
      end else begin
         $display("%0d failures", failures);
         $display("** rational_to_integer_rounder: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
